/* rtl/vas_pkg.sv */
// ----------------------------------------------------------------------------
// vas_pkg
// Shared codes, register indexes and transfer types of the valve actuation
// sequencer.
// ----------------------------------------------------------------------------
package vas_pkg;

   // Widths fixed by the field definitions
   localparam int CFG_W         = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int TIMER_W_DFLT  = 16;

   // Sequence steps
   localparam logic [3:0] ST_START_OPEN     = 4'd0;
   localparam logic [3:0] ST_WAIT_OPEN      = 4'd1;
   localparam logic [3:0] ST_START_CLOSE    = 4'd2;
   localparam logic [3:0] ST_WAIT_CLOSE     = 4'd3;
   localparam logic [3:0] ST_OPEN_SETTLE    = 4'd4;
   localparam logic [3:0] ST_CLOSE_SETTLE   = 4'd5;
   localparam logic [3:0] ST_FINISH         = 4'd6;
   localparam logic [3:0] ST_REP_OPEN       = 4'd7;
   localparam logic [3:0] ST_REP_WAIT_OPEN  = 4'd8;
   localparam logic [3:0] ST_REP_CLOSE      = 4'd9;
   localparam logic [3:0] ST_REP_WAIT_CLOSE = 4'd10;

   // Activity
   localparam logic [1:0] ACT_IDLE = 2'd0;
   localparam logic [1:0] ACT_RUN  = 2'd1;
   localparam logic [1:0] ACT_HALT = 2'd2;

   // Valve modes
   localparam logic [2:0] MD_NORMAL      = 3'd0;
   localparam logic [2:0] MD_FORCE       = 3'd1;
   localparam logic [2:0] MD_AUTO_OFF    = 3'd2;
   localparam logic [2:0] MD_OFF_IF_OK   = 3'd3;
   localparam logic [2:0] MD_OFF_IF_FAIL = 3'd4;
   localparam logic [2:0] MD_TEST        = 3'd5;

   // Commands
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_OPEN    = 3'd1;
   localparam logic [2:0] CMD_CLOSE   = 3'd2;
   localparam logic [2:0] CMD_REPEAT  = 3'd3;
   localparam logic [2:0] CMD_INVERSE = 3'd4;
   localparam logic [2:0] CMD_ON_OFF  = 3'd5;
   localparam logic [2:0] CMD_RETRY   = 3'd6;

   // Drive actions
   localparam logic [1:0] DRV_NONE  = 2'd0;
   localparam logic [1:0] DRV_OPEN  = 2'd1;
   localparam logic [1:0] DRV_CLOSE = 2'd2;
   localparam logic [1:0] DRV_OFF   = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE          = 2'd0;
   localparam logic [1:0] ERR_NOT_SAFE      = 2'd1;
   localparam logic [1:0] ERR_OPEN_TIMEOUT  = 2'd2;
   localparam logic [1:0] ERR_CLOSE_TIMEOUT = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_OPEN_TIMEOUT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLOSE_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OPEN_SETTLE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CLOSE_SETTLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IGNORE_SENSOR = 3'd5;

   typedef struct packed {
      logic [CFG_W-1:0] open_timeout_ticks;
      logic [CFG_W-1:0] close_timeout_ticks;
      logic [CFG_W-1:0] open_settle_ticks;
      logic [CFG_W-1:0] close_settle_ticks;
      logic [CFG_W-1:0] repeat_period_ticks;
      logic             ignore_sensor;
   } cfg_type;

   typedef struct packed {
      logic [3:0] step;
      logic [1:0] act;
      logic [2:0] mode;
      logic       test_flag;
      logic       vacuum_flag;
      logic [3:0] retry_step;
      logic [1:0] last_error;
   } state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [2:0] valve_mode;
      logic       sensed_open;
      logic       sensed_closed;
      logic       motion_safe;
      logic       interlock;
      logic       estop;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [1:0] drive;
      logic       busy_res;
      logic       halted;
      logic [1:0] error_code;
      logic       test_passed;
      logic       vacuum_on;
   } rsp_type;

endpackage

/* rtl/vas_cfg.sv */
// ----------------------------------------------------------------------------
// vas_cfg
// Configuration register file: decodes csr writes into the timing limits and
// the sensor bypass.
// ----------------------------------------------------------------------------
module vas_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [vas_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [vas_pkg::CFG_W-1:0]        wr_data,
   output vas_pkg::cfg_type                 cfg
);

   vas_pkg::cfg_type cfg_ff;
   vas_pkg::cfg_type cfg_in;

   // Decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            vas_pkg::REG_OPEN_TIMEOUT:  cfg_in.open_timeout_ticks  = wr_data;
            vas_pkg::REG_CLOSE_TIMEOUT: cfg_in.close_timeout_ticks = wr_data;
            vas_pkg::REG_OPEN_SETTLE:   cfg_in.open_settle_ticks   = wr_data;
            vas_pkg::REG_CLOSE_SETTLE:  cfg_in.close_settle_ticks  = wr_data;
            vas_pkg::REG_REPEAT_PERIOD: cfg_in.repeat_period_ticks = wr_data;
            vas_pkg::REG_IGNORE_SENSOR: cfg_in.ignore_sensor       = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/vas_core.sv */
// ----------------------------------------------------------------------------
// vas_core
// Next-state logic: applies one command, then advances the running sequence
// by one step and forms the result of the item.
// ----------------------------------------------------------------------------
module vas_core #(
   parameter int TIMER_WIDTH = vas_pkg::TIMER_W_DFLT
) (
   input  vas_pkg::req_type         req,
   input  vas_pkg::cfg_type         cfg,
   input  vas_pkg::state_type       state_cur,
   input  logic [TIMER_WIDTH-1:0]   cnt_cur,
   output vas_pkg::state_type       state_nxt,
   output logic [TIMER_WIDTH-1:0]   cnt_nxt,
   output vas_pkg::rsp_type         rsp
);

   localparam int CMP_W = (TIMER_WIDTH > vas_pkg::CFG_W) ? TIMER_WIDTH : vas_pkg::CFG_W;

   vas_pkg::state_type      st;
   logic [TIMER_WIDTH-1:0]  cnt;
   logic [TIMER_WIDTH-1:0]  cnt_inc;
   logic [vas_pkg::CFG_W-1:0] lim;
   logic                    expired;
   logic [2:0]              mode_l;
   logic                    may_start;
   logic                    acc;
   logic [1:0]              drv;
   logic                    off_fail;
   logic                    op;

   // Saturating tick count for the wait steps
   assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + TIMER_WIDTH'(1);

   always_comb begin
      st        = state_cur;
      cnt       = cnt_cur;
      acc       = 1'b0;
      drv       = vas_pkg::DRV_NONE;
      lim       = '0;
      op        = 1'b0;
      mode_l    = (req.valve_mode > vas_pkg::MD_TEST) ? vas_pkg::MD_NORMAL : req.valve_mode;
      may_start = (state_cur.act == vas_pkg::ACT_IDLE) && !req.interlock && !req.estop;

      // Apply the command
      case (req.cmd)
         vas_pkg::CMD_OPEN, vas_pkg::CMD_CLOSE, vas_pkg::CMD_INVERSE: begin
            if (may_start) begin
               op = (req.cmd == vas_pkg::CMD_OPEN) ||
                    (req.cmd == vas_pkg::CMD_INVERSE && !req.sensed_open);
               st.step      = op ? vas_pkg::ST_START_OPEN : vas_pkg::ST_START_CLOSE;
               st.act       = vas_pkg::ACT_RUN;
               st.mode      = mode_l;
               st.test_flag = 1'b0;
               acc          = 1'b1;
            end
         end
         vas_pkg::CMD_REPEAT: begin
            if (may_start) begin
               st.step = vas_pkg::ST_REP_OPEN;
               st.act  = vas_pkg::ACT_RUN;
               st.mode = vas_pkg::MD_FORCE;
               acc     = 1'b1;
            end
         end
         vas_pkg::CMD_ON_OFF: begin
            if (state_cur.act == vas_pkg::ACT_IDLE) begin
               if (req.sensed_open) begin
                  drv = vas_pkg::DRV_OFF;
               end else begin
                  st.step = vas_pkg::ST_START_OPEN;
                  st.act  = vas_pkg::ACT_RUN;
               end
               st.mode      = mode_l;
               st.test_flag = 1'b0;
               acc          = 1'b1;
            end
         end
         vas_pkg::CMD_RETRY: begin
            if (state_cur.act == vas_pkg::ACT_HALT && !req.interlock && !req.estop) begin
               st.last_error = vas_pkg::ERR_NONE;
               st.step       = st.retry_step;
               st.act        = vas_pkg::ACT_RUN;
               acc           = 1'b1;
            end
         end
         default: ;
      endcase

      // Pick the limit of the current wait step
      case (st.step)
         vas_pkg::ST_WAIT_OPEN:    lim = cfg.open_timeout_ticks;
         vas_pkg::ST_WAIT_CLOSE:   lim = cfg.close_timeout_ticks;
         vas_pkg::ST_OPEN_SETTLE:  lim = cfg.open_settle_ticks;
         vas_pkg::ST_CLOSE_SETTLE: lim = cfg.close_settle_ticks;
         default:                  lim = cfg.repeat_period_ticks;
      endcase
      expired  = CMP_W'(cnt_inc) >= CMP_W'(lim);
      off_fail = (st.mode == vas_pkg::MD_AUTO_OFF) || (st.mode == vas_pkg::MD_OFF_IF_FAIL);

      // Advance the running sequence by one step
      if (st.act == vas_pkg::ACT_RUN) begin
         case (st.step)
            vas_pkg::ST_START_OPEN, vas_pkg::ST_START_CLOSE: begin
               op = (st.step == vas_pkg::ST_START_OPEN);
               if (!req.motion_safe) begin
                  st.last_error = vas_pkg::ERR_NOT_SAFE;
                  st.retry_step = st.step;
                  st.act        = vas_pkg::ACT_HALT;
               end else begin
                  st.last_error = vas_pkg::ERR_NONE;
                  drv = op ? vas_pkg::DRV_OPEN : vas_pkg::DRV_CLOSE;
                  cnt = '0;
                  if (st.mode == vas_pkg::MD_FORCE) begin
                     st.act = vas_pkg::ACT_IDLE;
                  end else begin
                     st.step = op ? vas_pkg::ST_WAIT_OPEN : vas_pkg::ST_WAIT_CLOSE;
                  end
               end
            end
            vas_pkg::ST_WAIT_OPEN: begin
               if (req.sensed_open || cfg.ignore_sensor) begin
                  st.test_flag   = 1'b1;
                  st.vacuum_flag = 1'b1;
                  cnt = '0;
                  st.step = (cfg.open_settle_ticks != '0) ? vas_pkg::ST_OPEN_SETTLE
                                                          : vas_pkg::ST_FINISH;
               end else if (cfg.open_timeout_ticks != '0) begin
                  cnt = cnt_inc;
                  if (expired) begin
                     if (off_fail) begin
                        drv = vas_pkg::DRV_OFF;
                     end
                     if (st.mode == vas_pkg::MD_TEST) begin
                        st.vacuum_flag = 1'b0;
                        drv            = vas_pkg::DRV_OFF;
                        st.act         = vas_pkg::ACT_IDLE;
                     end else begin
                        st.last_error = vas_pkg::ERR_OPEN_TIMEOUT;
                        st.retry_step = vas_pkg::ST_START_OPEN;
                        st.act        = vas_pkg::ACT_HALT;
                     end
                  end
               end
            end
            vas_pkg::ST_WAIT_CLOSE: begin
               if (req.sensed_closed || cfg.ignore_sensor) begin
                  st.test_flag = 1'b1;
                  cnt = '0;
                  st.step = (cfg.close_settle_ticks != '0) ? vas_pkg::ST_CLOSE_SETTLE
                                                           : vas_pkg::ST_FINISH;
               end else if (cfg.close_timeout_ticks != '0) begin
                  cnt = cnt_inc;
                  if (expired) begin
                     if (off_fail) begin
                        drv = vas_pkg::DRV_OFF;
                     end
                     st.last_error = vas_pkg::ERR_CLOSE_TIMEOUT;
                     st.retry_step = vas_pkg::ST_START_CLOSE;
                     st.act        = vas_pkg::ACT_HALT;
                  end
               end
            end
            vas_pkg::ST_OPEN_SETTLE, vas_pkg::ST_CLOSE_SETTLE: begin
               cnt = cnt_inc;
               if (expired) begin
                  st.step = vas_pkg::ST_FINISH;
               end
            end
            vas_pkg::ST_FINISH: begin
               if (st.mode == vas_pkg::MD_AUTO_OFF || st.mode == vas_pkg::MD_OFF_IF_OK) begin
                  drv = vas_pkg::DRV_OFF;
               end
               st.act = vas_pkg::ACT_IDLE;
            end
            vas_pkg::ST_REP_OPEN, vas_pkg::ST_REP_CLOSE: begin
               op = (st.step == vas_pkg::ST_REP_OPEN);
               if (!req.motion_safe) begin
                  st.last_error = vas_pkg::ERR_NOT_SAFE;
                  st.retry_step = st.step;
                  st.act        = vas_pkg::ACT_HALT;
               end else begin
                  drv = op ? vas_pkg::DRV_OPEN : vas_pkg::DRV_CLOSE;
                  cnt = '0;
                  st.step = op ? vas_pkg::ST_REP_WAIT_OPEN : vas_pkg::ST_REP_WAIT_CLOSE;
               end
            end
            vas_pkg::ST_REP_WAIT_OPEN, vas_pkg::ST_REP_WAIT_CLOSE: begin
               op = (st.step == vas_pkg::ST_REP_WAIT_OPEN);
               if (cfg.repeat_period_ticks != '0) begin
                  cnt = cnt_inc;
               end
               if (cfg.repeat_period_ticks == '0 || expired) begin
                  st.step = op ? vas_pkg::ST_REP_CLOSE : vas_pkg::ST_REP_OPEN;
               end
            end
            default: begin
               st.act = vas_pkg::ACT_IDLE;
            end
         endcase
      end
   end

   assign state_nxt = st;
   assign cnt_nxt   = cnt;

   // Form the result of the item
   assign rsp.accepted    = acc;
   assign rsp.drive       = drv;
   assign rsp.busy_res    = (st.act == vas_pkg::ACT_RUN);
   assign rsp.halted      = (st.act == vas_pkg::ACT_HALT);
   assign rsp.error_code  = st.last_error;
   assign rsp.test_passed = st.test_flag;
   assign rsp.vacuum_on   = st.vacuum_flag;

endmodule

/* rtl/valve_actuation_sequencer.sv */
// ----------------------------------------------------------------------------
// valve_actuation_sequencer
// Flow: a request transfer is held in the input register, processed by the
//   step logic once the output register is free or draining, and its result
//   is presented from the output register.
// Throughput: one request per cycle while rsp_ready does not stall the output;
//   the step logic between the two registers handles one item per clock.
// Reset: sequencer idle at start open, counters, errors and valid flags cleared.
// ----------------------------------------------------------------------------
module valve_actuation_sequencer #(
   parameter int TIMER_WIDTH = vas_pkg::TIMER_W_DFLT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_cmd,
   input  logic [2:0]                       req_valve_mode,
   input  logic                             req_sensed_open,
   input  logic                             req_sensed_closed,
   input  logic                             req_motion_safe,
   input  logic                             req_interlock,
   input  logic                             req_estop,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [1:0]                       rsp_drive,
   output logic                             rsp_busy_res,
   output logic                             rsp_halted,
   output logic [1:0]                       rsp_error_code,
   output logic                             rsp_test_passed,
   output logic                             rsp_vacuum_on,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vas_pkg::CFG_W-1:0]        csr_wdata
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   vas_pkg::req_type        in_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   vas_pkg::rsp_type        out_ff;
   vas_pkg::state_type      state_ff;
   vas_pkg::state_type      state_in;
   logic [TIMER_WIDTH-1:0]  cnt_ff;
   logic [TIMER_WIDTH-1:0]  cnt_in;
   vas_pkg::cfg_type        cfg;
   vas_pkg::rsp_type        rsp_in;
   logic                    fire;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   vas_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Process the held item when the output register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   vas_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .req       (in_ff),
      .cfg       (cfg),
      .state_cur (state_ff),
      .cnt_cur   (cnt_ff),
      .state_nxt (state_in),
      .cnt_nxt   (cnt_in),
      .rsp       (rsp_in)
   );

   // Control and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         state_ff     <= '{step:        vas_pkg::ST_START_OPEN,
                           act:         vas_pkg::ACT_IDLE,
                           mode:        vas_pkg::MD_NORMAL,
                           test_flag:   1'b0,
                           vacuum_flag: 1'b0,
                           retry_step:  vas_pkg::ST_START_OPEN,
                           last_error:  vas_pkg::ERR_NONE};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // Payload registers: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= '{cmd:           req_cmd,
                    valve_mode:    req_valve_mode,
                    sensed_open:   req_sensed_open,
                    sensed_closed: req_sensed_closed,
                    motion_safe:   req_motion_safe,
                    interlock:     req_interlock,
                    estop:         req_estop};
      end
      if (fire) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_accepted    = out_ff.accepted;
   assign rsp_drive       = out_ff.drive;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_halted      = out_ff.halted;
   assign rsp_error_code  = out_ff.error_code;
   assign rsp_test_passed = out_ff.test_passed;
   assign rsp_vacuum_on   = out_ff.vacuum_on;

   // A halted sequencer always carries an error code
   a_halt_has_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff.act == vas_pkg::ACT_HALT) |-> (state_ff.last_error != vas_pkg::ERR_NONE))
      else $error("halted without an error code");

   // A held request that is not processed stays in the input register
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_ff)))
      else $error("held request lost or changed");

   // Sequencer state moves only when an item is processed
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(state_ff) && $stable(cnt_ff)))
      else $error("sequencer state changed without an item");

   // A stalled result is not overwritten
   a_output_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !fire)
      else $error("result overwritten while stalled");

endmodule
